// ===== hdl/cks_pkg.sv =====
package cks_pkg;

  localparam int WORD_W   = 64;
  localparam int KEY_W    = 4 * WORD_W;
  localparam int SLOT_W   = 6;
  localparam int HELD_W   = 7;
  // wide enough for any count up to the largest table plus one
  localparam int WIDE_W   = 9;

  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_REVOKE   = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_GET      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EXISTS  = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

endpackage

// ===== hdl/cks_key_mem.sv =====
module cks_key_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  cks_pkg::key_t       wdata,
  input  logic [AW-1:0]       raddr,
  output cks_pkg::key_t       rdata
);

  cks_pkg::key_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/cks_key_cmp.sv =====
module cks_key_cmp (
  input  cks_pkg::key_t entry,
  input  cks_pkg::key_t probe,
  output logic          match
);

  // compare word by word, then combine
  logic [3:0] word_eq;

  always_comb begin
    for (int w = 0; w < 4; w++) begin
      word_eq[w] = (entry[w*cks_pkg::WORD_W +: cks_pkg::WORD_W] ==
                    probe[w*cks_pkg::WORD_W +: cks_pkg::WORD_W]);
    end
  end

  assign match = &word_eq;

endmodule

// ===== hdl/compacting_key_set_table.sv =====
// channel  direction  handshake             word
// -------  ---------  --------------------  ----------------------------------------
// in       sink       in_valid / in_stall   op, key_w0..key_w3, slot_index
// out      source     out_valid / out_stall status, found, out_w0..out_w3, entries_held
//
// One command at a time. A lookup walks the key memory one entry per cycle through a
// single read port and one shared 256-bit comparator. Revoke then compacts each moved
// entry (read next in S_SH_RD, write current in S_SH_WR). An in-range get reads its
// slot through S_GET; an out-of-range get or a full add goes straight to S_DONE.
// Reset (rst, synchronous) empties the set; key memory contents are never cleared and
// are only used below the count. in_stall is high from accept until the result is
// loaded; a result waiting under out_stall holds the block in its final state.
module compacting_key_set_table #(
  parameter int MAX_KEYS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     op,
  input  logic [cks_pkg::WORD_W-1:0]     key_w0,
  input  logic [cks_pkg::WORD_W-1:0]     key_w1,
  input  logic [cks_pkg::WORD_W-1:0]     key_w2,
  input  logic [cks_pkg::WORD_W-1:0]     key_w3,
  input  logic [cks_pkg::SLOT_W-1:0]     slot_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     status,
  output logic                           found,
  output logic [cks_pkg::WORD_W-1:0]     out_w0,
  output logic [cks_pkg::WORD_W-1:0]     out_w1,
  output logic [cks_pkg::WORD_W-1:0]     out_w2,
  output logic [cks_pkg::WORD_W-1:0]     out_w3,
  output logic [cks_pkg::HELD_W-1:0]     entries_held
);

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int WW = cks_pkg::WORD_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_SH_RD = 6'b000100,
    S_SH_WR = 6'b001000,
    S_GET   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                 state, state_next;
  logic [CW-1:0]          held_count, held_count_next;
  logic [CW-1:0]          scan_idx, scan_idx_next;
  logic                   pend, pend_next;
  logic [CW-1:0]          pend_idx, pend_idx_next;
  logic [CW-1:0]          sh_idx, sh_idx_next;
  cks_pkg::op_t           op_q, op_q_next;
  cks_pkg::key_t          key_q, key_q_next;
  cks_pkg::status_t       res_status, res_status_next;
  logic                   res_found, res_found_next;
  cks_pkg::key_t          res_key, res_key_next;

  logic                   out_valid_next;
  logic                   load_out;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  cks_pkg::key_t          mem_wdata;
  logic [AW-1:0]          mem_raddr;
  cks_pkg::key_t          mem_rdata;
  logic                   match;

  logic [cks_pkg::WIDE_W-1:0] slot_wide;
  logic [CW:0]                sh_nxt;

  cks_key_mem #(
    .DEPTH (MAX_KEYS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // the one comparator: stored entry against the latched key
  cks_key_cmp u_cmp (
    .entry (mem_rdata),
    .probe (key_q),
    .match (match)
  );

  assign in_stall  = (state != S_IDLE);
  assign slot_wide = cks_pkg::WIDE_W'(slot_index);
  assign sh_nxt    = (CW+1)'(sh_idx) + (CW+1)'(1);

  always_comb begin
    state_next      = state;
    held_count_next = held_count;
    scan_idx_next   = scan_idx;
    pend_next       = pend;
    pend_idx_next   = pend_idx;
    sh_idx_next     = sh_idx;
    op_q_next       = op_q;
    key_q_next      = key_q;
    res_status_next = res_status;
    res_found_next  = res_found;
    res_key_next    = res_key;
    mem_we          = 1'b0;
    mem_waddr       = held_count[AW-1:0];
    mem_wdata       = key_q;
    mem_raddr       = scan_idx[AW-1:0];
    load_out        = 1'b0;

    case (state)
      S_IDLE: begin
        // address the get slot now so its data lands on the accept edge
        mem_raddr = slot_wide[AW-1:0];
        if (in_valid) begin
          op_q_next       = cks_pkg::op_t'(op);
          key_q_next      = {key_w3, key_w2, key_w1, key_w0};
          res_status_next = cks_pkg::ST_OK;
          res_found_next  = 1'b0;
          res_key_next    = '0;
          scan_idx_next   = '0;
          pend_next       = 1'b0;
          case (cks_pkg::op_t'(op))
            cks_pkg::OP_GET: begin
              if (slot_wide >= cks_pkg::WIDE_W'(held_count)) begin
                res_status_next = cks_pkg::ST_MISSING;
                state_next      = S_DONE;
              end else begin
                state_next = S_GET;
              end
            end
            cks_pkg::OP_ADD: begin
              // fullness wins over the duplicate check
              if (cks_pkg::WIDE_W'(held_count) >= cks_pkg::WIDE_W'(MAX_KEYS)) begin
                res_status_next = cks_pkg::ST_FULL;
                state_next      = S_DONE;
              end else begin
                state_next = S_SCAN;
              end
            end
            default: begin
              state_next = S_SCAN;
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue one read per cycle; compare the entry read last cycle
        pend_next     = (scan_idx < held_count);
        pend_idx_next = scan_idx;
        if (scan_idx < held_count) begin
          scan_idx_next = scan_idx + CW'(1);
        end
        if (pend && match) begin
          case (op_q)
            cks_pkg::OP_ADD: begin
              res_status_next = cks_pkg::ST_EXISTS;
              state_next      = S_DONE;
            end
            cks_pkg::OP_REVOKE: begin
              sh_idx_next = pend_idx;
              state_next  = S_SH_RD;
            end
            default: begin
              res_found_next = 1'b1;
              state_next     = S_DONE;
            end
          endcase
        end else if (!(scan_idx < held_count)) begin
          // walked past the last entry without a hit
          case (op_q)
            cks_pkg::OP_ADD: begin
              mem_we          = 1'b1;
              held_count_next = held_count + CW'(1);
            end
            cks_pkg::OP_REVOKE: begin
              res_status_next = cks_pkg::ST_MISSING;
            end
            default: begin
              res_found_next = 1'b0;
            end
          endcase
          state_next = S_DONE;
        end
      end

      S_SH_RD: begin
        mem_raddr = sh_nxt[AW-1:0];
        if (sh_nxt < (CW+1)'(held_count)) begin
          state_next = S_SH_WR;
        end else begin
          // last slot reached: drop it from the count
          held_count_next = held_count - CW'(1);
          state_next      = S_DONE;
        end
      end

      S_SH_WR: begin
        // move the later entry down one place
        mem_we      = 1'b1;
        mem_waddr   = sh_idx[AW-1:0];
        mem_wdata   = mem_rdata;
        sh_idx_next = sh_nxt[CW-1:0];
        state_next  = S_SH_RD;
      end

      S_GET: begin
        res_key_next = mem_rdata;
        state_next   = S_DONE;
      end

      S_DONE: begin
        // hold until the output register is free
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_valid_next = load_out | (out_valid & out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_count <= '0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      held_count <= held_count_next;
      pend       <= pend_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx   <= scan_idx_next;
    pend_idx   <= pend_idx_next;
    sh_idx     <= sh_idx_next;
    op_q       <= op_q_next;
    key_q      <= key_q_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    res_key    <= res_key_next;
    if (load_out) begin
      status       <= res_status;
      found        <= res_found;
      out_w0       <= res_key[0*WW +: WW];
      out_w1       <= res_key[1*WW +: WW];
      out_w2       <= res_key[2*WW +: WW];
      out_w3       <= res_key[3*WW +: WW];
      entries_held <= cks_pkg::HELD_W'(held_count);
    end
  end

  // count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cks_pkg::WIDE_W'(held_count) <= cks_pkg::WIDE_W'(MAX_KEYS))
    else $error("held count exceeds table size");

  // an accepted command always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != S_IDLE))
    else $error("accepted command did not start");

  // count moves by at most one per command step
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (held_count == $past(held_count) ||
              held_count == $past(held_count) + CW'(1) ||
              held_count == $past(held_count) - CW'(1)))
    else $error("held count jumped");

  // a result is loaded only when the output register can take it
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || !out_stall))
    else $error("result overwrote a waiting word");

endmodule
